### src/lcds_pkg.sv
// ----------------------------------------------------------------------------
// lcds_pkg
// Shared types and constants for the LED chase display sequencer.
// ----------------------------------------------------------------------------
package lcds_pkg;

  // number of LEDs kept in display memory
  localparam int LED_COUNT = 16;
  localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  // field widths
  localparam int DELAY_W     = 16;
  localparam int LEVEL_W     = 4;
  localparam int FUNC_W      = 3;
  localparam int INDEX_W     = 4;
  localparam int MASK_OUT_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [DELAY_W-1:0] TICK_MAX = {DELAY_W{1'b1}};

  // reset values of the configuration registers
  localparam logic [DELAY_W-1:0] STEP_GAP_RST    = 16'd100;
  localparam logic [DELAY_W-1:0] LIT_HOLD_RST    = 16'd1000;
  localparam logic [DELAY_W-1:0] DARK_GAP_RST    = 16'd1000;
  localparam logic [LEVEL_W-1:0] BRIGHT_IDLE_RST = 4'd1;
  localparam logic [LEVEL_W-1:0] BRIGHT_PLAY_RST = 4'd15;

  // item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK       = 3'd0,
    FUNC_START_IDLE = 3'd1,
    FUNC_BLINK      = 3'd2,
    FUNC_SLEEP      = 3'd3,
    FUNC_WAKEUP     = 3'd4
  } func_t;

  // chase phases
  typedef enum logic [2:0] {
    PH_NONE     = 3'd0,
    PH_LIGHT_UP = 3'd1,
    PH_WAIT_ON  = 3'd2,
    PH_TURN_OFF = 3'd3,
    PH_WAIT_OFF = 3'd4
  } phase_t;

  // blink rates
  typedef enum logic [1:0] {
    BLINK_OFF  = 2'd0,
    BLINK_FAST = 2'd1,
    BLINK_SLOW = 2'd2
  } blink_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_GAP    = 3'd0,
    CFG_LIT_HOLD    = 3'd1,
    CFG_DARK_GAP    = 3'd2,
    CFG_BRIGHT_IDLE = 3'd3,
    CFG_BRIGHT_PLAY = 3'd4
  } cfg_idx_t;

  // configuration register bank contents
  typedef struct packed {
    logic [DELAY_W-1:0] step_gap;
    logic [DELAY_W-1:0] lit_hold;
    logic [DELAY_W-1:0] dark_gap;
    logic [LEVEL_W-1:0] bright_idle;
    logic [LEVEL_W-1:0] bright_play;
  } cfg_t;

  // one input item as held in the input register
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] led_index;
    logic               fast_blink;
  } item_t;

endpackage

### src/lcds_cfg_regs.sv
// ----------------------------------------------------------------------------
// lcds_cfg_regs
// Configuration register bank: delays and brightness levels.
// ----------------------------------------------------------------------------
module lcds_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lcds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcds_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lcds_pkg::cfg_t                   cfg
);
  import lcds_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP_GAP:    cfg_nxt.step_gap    = cfg_data[DELAY_W-1:0];
        CFG_LIT_HOLD:    cfg_nxt.lit_hold    = cfg_data[DELAY_W-1:0];
        CFG_DARK_GAP:    cfg_nxt.dark_gap    = cfg_data[DELAY_W-1:0];
        CFG_BRIGHT_IDLE: cfg_nxt.bright_idle = cfg_data[LEVEL_W-1:0];
        CFG_BRIGHT_PLAY: cfg_nxt.bright_play = cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_gap    <= STEP_GAP_RST;
      cfg_r.lit_hold    <= LIT_HOLD_RST;
      cfg_r.dark_gap    <= DARK_GAP_RST;
      cfg_r.bright_idle <= BRIGHT_IDLE_RST;
      cfg_r.bright_play <= BRIGHT_PLAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/lcds_seq_core.sv
// ----------------------------------------------------------------------------
// lcds_seq_core
// Display state and chase sequencer; applies one item per step and holds
// the resulting display state, which doubles as the result register.
// ----------------------------------------------------------------------------
module lcds_seq_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  lcds_pkg::item_t                   item,
  input  lcds_pkg::cfg_t                    cfg,
  output logic [lcds_pkg::MASK_OUT_W-1:0]   led_mask,
  output logic [1:0]                        blink_mode,
  output logic [lcds_pkg::LEVEL_W-1:0]      level,
  output logic                              asleep,
  output logic [2:0]                        phase
);
  import lcds_pkg::*;

  phase_t               phase_r,    phase_nxt;
  logic [DELAY_W-1:0]   tick_r,     tick_nxt;
  logic [LED_IDX_W-1:0] next_led_r, next_led_nxt;
  logic [LED_COUNT-1:0] mask_r,     mask_nxt;
  logic [LEVEL_W-1:0]   level_r,    level_nxt;
  blink_t               blink_r,    blink_nxt;
  logic                 sleep_r,    sleep_nxt;

  logic [DELAY_W-1:0]   tick_inc;
  logic                 led_last;
  logic [LED_IDX_W-1:0] led_inc;
  logic [LED_COUNT-1:0] blink_mask;

  // saturating tick count and led pointer wrap
  assign tick_inc = (tick_r == TICK_MAX) ? tick_r : tick_r + 1'b1;
  assign led_last = (next_led_r == LED_IDX_W'(LED_COUNT - 1));
  assign led_inc  = led_last ? '0 : next_led_r + 1'b1;

  // one-hot mask for the blink command, empty when the index is out of range
  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      blink_mask[i] = (int'(item.led_index) == i);
    end
  end

  // next state and display update
  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    next_led_nxt = next_led_r;
    mask_nxt     = mask_r;
    level_nxt    = level_r;
    blink_nxt    = blink_r;
    sleep_nxt    = sleep_r;
    if (step) begin
      case (item.func)
        FUNC_TICK: begin
          tick_nxt = tick_inc;
          unique case (phase_r)
            PH_LIGHT_UP: begin
              if (tick_inc >= cfg.step_gap) begin
                tick_nxt             = '0;
                mask_nxt[next_led_r] = 1'b1;
                next_led_nxt         = led_inc;
                if (led_last) begin
                  phase_nxt = PH_WAIT_ON;
                end
              end
            end
            PH_WAIT_ON: begin
              if (tick_inc >= cfg.lit_hold) begin
                tick_nxt  = '0;
                phase_nxt = PH_TURN_OFF;
              end
            end
            PH_TURN_OFF: begin
              if (tick_inc >= cfg.step_gap) begin
                tick_nxt             = '0;
                mask_nxt[next_led_r] = 1'b0;
                next_led_nxt         = led_inc;
                if (led_last) begin
                  phase_nxt = PH_WAIT_OFF;
                end
              end
            end
            PH_WAIT_OFF: begin
              if (tick_inc >= cfg.dark_gap) begin
                tick_nxt  = '0;
                mask_nxt  = '0;
                phase_nxt = PH_LIGHT_UP;
              end
            end
            default: ;
          endcase
        end
        FUNC_START_IDLE: begin
          level_nxt    = cfg.bright_idle;
          blink_nxt    = BLINK_OFF;
          mask_nxt     = '0;
          phase_nxt    = PH_LIGHT_UP;
          next_led_nxt = '0;
          tick_nxt     = '0;
        end
        FUNC_BLINK: begin
          phase_nxt = PH_NONE;
          level_nxt = cfg.bright_play;
          mask_nxt  = blink_mask;
          blink_nxt = item.fast_blink ? BLINK_FAST : BLINK_SLOW;
        end
        FUNC_SLEEP: begin
          phase_nxt = PH_NONE;
          mask_nxt  = '0;
          sleep_nxt = 1'b1;
        end
        FUNC_WAKEUP: begin
          phase_nxt = PH_NONE;
          sleep_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_NONE;
      tick_r     <= '0;
      next_led_r <= '0;
      mask_r     <= '0;
      level_r    <= '0;
      blink_r    <= BLINK_OFF;
      sleep_r    <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      next_led_r <= next_led_nxt;
      mask_r     <= mask_nxt;
      level_r    <= level_nxt;
      blink_r    <= blink_nxt;
      sleep_r    <= sleep_nxt;
    end
  end

  // visible part of display memory
  generate
    if (LED_COUNT >= MASK_OUT_W) begin : g_mask_wide
      assign led_mask = mask_r[MASK_OUT_W-1:0];
    end else begin : g_mask_narrow
      assign led_mask = {{(MASK_OUT_W - LED_COUNT){1'b0}}, mask_r};
    end
  endgenerate

  assign blink_mode = blink_r;
  assign level      = level_r;
  assign asleep     = sleep_r;
  assign phase      = phase_r;

endmodule

### src/led_chase_display_sequencer.sv
// ----------------------------------------------------------------------------
// led_chase_display_sequencer
// Path: an accepted item passes the input register, then the display state
// register, whose contents are the result.
// Throughput: one item per cycle while out_ready takes each result; the state
// update is one saturating add, one 16-bit compare and a mask bit update.
// Reset: synchronous, active low; delays 100/1000/1000, brightness 1/15,
// display dark, awake, no chase running.
// ----------------------------------------------------------------------------
module led_chase_display_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  // item input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lcds_pkg::FUNC_W-1:0]      in_func,
  input  logic [lcds_pkg::INDEX_W-1:0]     in_led_index,
  input  logic                             in_fast_blink,
  // result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lcds_pkg::MASK_OUT_W-1:0]  out_led_mask,
  output logic [1:0]                       out_blink_mode,
  output logic [lcds_pkg::LEVEL_W-1:0]     out_level,
  output logic                             out_asleep,
  output logic [2:0]                       out_phase,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [lcds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcds_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lcds_pkg::*;

  cfg_t  cfg;
  item_t item_r;
  logic  in_valid_r;
  logic  out_valid_r;
  logic  step;

  // an item moves into the state stage once the result slot is free
  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func       <= in_func;
      item_r.led_index  <= in_led_index;
      item_r.fast_blink <= in_fast_blink;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  lcds_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcds_seq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (item_r),
    .cfg        (cfg),
    .led_mask   (out_led_mask),
    .blink_mode (out_blink_mode),
    .level      (out_level),
    .asleep     (out_asleep),
    .phase      (out_phase)
  );

endmodule
